// File: hdl/lbps_pkg.sv
// Shared types, codes and constants of the LED bar pattern sequencer.
package lbps_pkg;

    // Pattern modes; idle follows a lock command.
    typedef enum logic [2:0] {
        MODE_FIXED  = 3'd0,
        MODE_COUNT  = 3'd1,
        MODE_ROTATE = 3'd2,
        MODE_BOUNCE = 3'd3,
        MODE_IDLE   = 3'd4
    } t_mode;

    // Input word kinds.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Command codes.
    localparam logic [7:0] CMD_NONE   = 8'h00;
    localparam logic [7:0] CMD_FIXED  = 8'h81;
    localparam logic [7:0] CMD_COUNT  = 8'h41;
    localparam logic [7:0] CMD_ROTATE = 8'h21;
    localparam logic [7:0] CMD_BOUNCE = 8'h11;
    localparam logic [7:0] CMD_LOCK   = 8'h18;

    // Pattern constants.
    localparam logic [7:0] LED_FIXED     = 8'hAA;
    localparam logic [7:0] LED_OFF       = 8'h00;
    localparam logic [7:0] RING_INIT     = 8'h7F;
    localparam logic [7:0] COUNT_WRAP    = 8'hFF;
    localparam logic [3:0] BOUNCE_TOP    = 4'h8;
    localparam logic [3:0] BOUNCE_BOTTOM = 4'h1;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COUNT        = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ROTATE       = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_BOUNCE_SHOW  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_BOUNCE_BLANK = 8'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_COUNT_PERIOD        = 16'd16425;
    localparam logic [15:0] RST_ROTATE_PERIOD       = 16'd32850;
    localparam logic [15:0] RST_BOUNCE_SHOW_PERIOD  = 16'd32850;
    localparam logic [15:0] RST_BOUNCE_BLANK_PERIOD = 16'd4107;

    typedef struct packed {
        logic [15:0] count_period;
        logic [15:0] rotate_period;
        logic [15:0] bounce_show_period;
        logic [15:0] bounce_blank_period;
    } t_cfg;

    typedef struct packed {
        logic       func;
        logic [7:0] cmd_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  led_value;
        logic        unlocked;
        logic        timer_on;
        logic [15:0] timer_period;
    } t_out;

    // Reverses the four bits of a nibble.
    function automatic logic [3:0] mirror4(input logic [3:0] v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

// File: hdl/lbps_cfg_regs.sv
// Configuration registers holding the four timer periods.
module lbps_cfg_regs
    import lbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_ADDR_W-1:0] i_addr,
    input  logic [15:0]           i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Address decode; writes beyond the last register are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_addr)
                CFG_IDX_COUNT:        n_cfg.count_period        = i_data;
                CFG_IDX_ROTATE:       n_cfg.rotate_period       = i_data;
                CFG_IDX_BOUNCE_SHOW:  n_cfg.bounce_show_period  = i_data;
                CFG_IDX_BOUNCE_BLANK: n_cfg.bounce_blank_period = i_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_period        <= RST_COUNT_PERIOD;
            r_cfg.rotate_period       <= RST_ROTATE_PERIOD;
            r_cfg.bounce_show_period  <= RST_BOUNCE_SHOW_PERIOD;
            r_cfg.bounce_blank_period <= RST_BOUNCE_BLANK_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/lbps_pattern_core.sv
// Pattern state registers with their update and result logic.
module lbps_pattern_core
    import lbps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_in  i_in,
    input  t_cfg i_cfg,
    output t_out o_result
);

    logic       r_unlocked, n_unlocked;
    t_mode      r_mode, n_mode;
    logic [7:0] r_last_cmd, n_last_cmd;
    logic       r_rearm, n_rearm;
    logic [7:0] r_count, n_count;
    logic [7:0] r_ring, n_ring;
    logic [3:0] r_pos, n_pos;
    logic       r_up, n_up;
    logic       r_blank, n_blank;

    logic       timer_active;
    logic [7:0] count_inc;
    logic       bounce_up_next;

    // The timer runs in the three animated modes while unlocked.
    assign timer_active = r_unlocked &&
        (r_mode == MODE_COUNT || r_mode == MODE_ROTATE || r_mode == MODE_BOUNCE);
    assign count_inc = r_count + 8'd1;

    // Direction turns at either end of the bar.
    always_comb begin
        if (r_pos == BOUNCE_TOP) begin
            bounce_up_next = 1'b0;
        end else if (r_pos == BOUNCE_BOTTOM) begin
            bounce_up_next = 1'b1;
        end else begin
            bounce_up_next = r_up;
        end
    end

    // Next state for one accepted word.
    always_comb begin
        n_unlocked = r_unlocked;
        n_mode     = r_mode;
        n_last_cmd = r_last_cmd;
        n_rearm    = r_rearm;
        n_count    = r_count;
        n_ring     = r_ring;
        n_pos      = r_pos;
        n_up       = r_up;
        n_blank    = r_blank;
        if (i_step) begin
            if (i_in.func == FUNC_BYTE) begin
                if (r_unlocked || i_in.cmd_byte != CMD_NONE) begin
                    n_unlocked = 1'b1;
                    if (i_in.cmd_byte == CMD_LOCK) begin
                        // Lock: go idle, restore the animations, keep the counter.
                        n_mode     = MODE_IDLE;
                        n_unlocked = 1'b0;
                        n_last_cmd = CMD_NONE;
                        n_ring     = RING_INIT;
                        n_pos      = BOUNCE_TOP;
                        n_up       = 1'b0;
                        n_blank    = 1'b0;
                    end else begin
                        case (i_in.cmd_byte)
                            CMD_FIXED:  n_mode = MODE_FIXED;
                            CMD_COUNT:  n_mode = MODE_COUNT;
                            CMD_ROTATE: n_mode = MODE_ROTATE;
                            CMD_BOUNCE: n_mode = MODE_BOUNCE;
                            default:    n_mode = r_mode;
                        endcase
                        // Counter rearm sequence: count, zero, count clears it.
                        if (n_mode == MODE_COUNT) begin
                            if (r_last_cmd == CMD_COUNT && i_in.cmd_byte == CMD_NONE) begin
                                n_rearm = 1'b1;
                            end else if (r_last_cmd == CMD_COUNT &&
                                         i_in.cmd_byte == CMD_COUNT && r_rearm) begin
                                n_rearm = 1'b0;
                                n_count = 8'd0;
                            end else begin
                                n_rearm = 1'b0;
                            end
                        end
                        if (i_in.cmd_byte != CMD_NONE) begin
                            n_last_cmd = i_in.cmd_byte;
                        end
                    end
                end
            end else if (timer_active) begin
                case (r_mode)
                    MODE_COUNT: begin
                        n_count = (count_inc == COUNT_WRAP) ? 8'd0 : count_inc;
                    end
                    MODE_ROTATE: begin
                        n_ring = {r_ring[0], r_ring[7:1]};
                    end
                    default: begin
                        if (!r_blank) begin
                            n_blank = 1'b1;
                            n_up    = bounce_up_next;
                            n_pos   = bounce_up_next ? {r_pos[2:0], 1'b0}
                                                     : {1'b0, r_pos[3:1]};
                        end else begin
                            n_blank = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // Result seen from the state after this word.
    always_comb begin
        o_result.unlocked     = n_unlocked;
        o_result.timer_on     = 1'b0;
        o_result.led_value    = LED_OFF;
        o_result.timer_period = 16'd0;
        if (n_unlocked) begin
            unique case (n_mode)
                MODE_FIXED: begin
                    o_result.led_value = LED_FIXED;
                end
                MODE_COUNT: begin
                    o_result.led_value    = n_count;
                    o_result.timer_on     = 1'b1;
                    o_result.timer_period = i_cfg.count_period;
                end
                MODE_ROTATE: begin
                    o_result.led_value    = n_ring;
                    o_result.timer_on     = 1'b1;
                    o_result.timer_period = i_cfg.rotate_period;
                end
                MODE_BOUNCE: begin
                    o_result.timer_on = 1'b1;
                    if (n_blank) begin
                        o_result.timer_period = i_cfg.bounce_blank_period;
                    end else begin
                        o_result.led_value    = {mirror4(n_pos), n_pos};
                        o_result.timer_period = i_cfg.bounce_show_period;
                    end
                end
                default: begin
                    o_result.led_value = LED_OFF;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlocked <= 1'b0;
            r_mode     <= MODE_FIXED;
            r_last_cmd <= CMD_NONE;
            r_rearm    <= 1'b0;
            r_count    <= 8'd0;
            r_ring     <= RING_INIT;
            r_pos      <= BOUNCE_TOP;
            r_up       <= 1'b0;
            r_blank    <= 1'b0;
        end else begin
            r_unlocked <= n_unlocked;
            r_mode     <= n_mode;
            r_last_cmd <= n_last_cmd;
            r_rearm    <= n_rearm;
            r_count    <= n_count;
            r_ring     <= n_ring;
            r_pos      <= n_pos;
            r_up       <= n_up;
            r_blank    <= n_blank;
        end
    end

endmodule

// File: hdl/led_bar_pattern_sequencer_unit.sv
// Top level of the LED bar pattern sequencer: handshakes and result register.
// The sequencer takes one word (a command byte or a timer tick) per clock cycle while the input
// is ready, and returns exactly one result word for each, in the cycle after acceptance. The
// pattern state updates in a single pass of logic from the accepted word into the state
// registers, and the result register beside them holds the answer; the input stays ready while
// a result waits as long as the consumer takes it in the same cycle. Timer periods are written
// through a plain write port; the user must do so only while no word is in flight, unchecked by the block.
module led_bar_pattern_sequencer_unit
    import lbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out
);

    t_cfg cfg;
    t_out result;
    logic accept;
    logic r_out_valid;
    t_out r_out;

    lbps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lbps_pattern_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Ready whenever the result register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A running timer implies an unlocked block.
    a_timer_needs_unlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.timer_on |-> r_out.unlocked)
        else $error("timer on while locked");

    // A stopped timer reports a zero period.
    a_period_zero_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.timer_on |-> r_out.timer_period == 16'd0)
        else $error("nonzero period with timer off");

    // A locked block keeps the bar dark.
    a_dark_when_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.unlocked |-> r_out.led_value == LED_OFF)
        else $error("LEDs lit while locked");

    // Every accepted word leaves a result in the register on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word produced no result");

endmodule
